FILE: rtl/gbc_pkg.sv
package gbc_pkg;

	localparam int unsigned ROUNDS     = 32;
	localparam int unsigned RND_IDX_W  = $clog2(ROUNDS);
	localparam int unsigned KEY_WORDS  = 8;
	localparam int unsigned KEY_IDX_W  = $clog2(KEY_WORDS);
	localparam int unsigned PADDR_W    = 6;
	localparam int unsigned PDATA_W    = 64;

	typedef logic [31:0] word_t;
	typedef logic [KEY_WORDS-1:0][31:0] key_words_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;
	typedef logic [RND_IDX_W-1:0] rnd_idx_t;

	typedef struct packed {
		word_t left;
		word_t right;
	} half_pair_t;

	typedef enum logic [2:0] {
		REG_KEY_01  = 3'd0,
		REG_KEY_23  = 3'd1,
		REG_KEY_45  = 3'd2,
		REG_KEY_67  = 3'd3,
		REG_DECRYPT = 3'd4
	} reg_idx_t;

	localparam logic [3:0] SBOX [8][16] = '{
		'{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
		  4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
		'{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
		  4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
		'{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
		  4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
		'{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
		  4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
		'{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
		  4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
		'{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
		  4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
		'{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
		  4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
		'{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
		  4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
	};

	// most significant nibble goes through box 0
	function automatic word_t substitute(word_t w);
		word_t res;
		res = '0;
		for (int n = 0; n < 8; n++) begin
			res[(7-n)*4 +: 4] = SBOX[n][w[(7-n)*4 +: 4]];
		end
		return res;
	endfunction

	// key word used by a pipeline stage, decrypt walks the schedule backwards
	function automatic key_idx_t key_idx(rnd_idx_t stage, logic decrypt);
		rnd_idx_t r;
		r = decrypt ? rnd_idx_t'(ROUNDS - 1) - stage : stage;
		if (r < rnd_idx_t'(24)) begin
			return r[KEY_IDX_W-1:0];
		end
		return key_idx_t'(KEY_WORDS - 1) - r[KEY_IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/gbc_if.sv
interface gbc_in_if import gbc_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t left_half;
	word_t right_half;

	modport source (output valid, output left_half, output right_half, input ready);
	modport sink   (input valid, input left_half, input right_half, output ready);
endinterface

interface gbc_out_if import gbc_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t out_left;
	word_t out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

FILE: rtl/gbc_regs.sv
module gbc_regs import gbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output key_words_t         keys,
	output logic               decrypt
);

	logic [3:0][PDATA_W-1:0] key_pair_q;
	logic                    decrypt_q;
	logic [2:0]              idx;
	logic                    wr_en;

	assign idx    = paddr[PADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pair_q <= '0;
			decrypt_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_KEY_01:  key_pair_q[0] <= pwdata;
				REG_KEY_23:  key_pair_q[1] <= pwdata;
				REG_KEY_45:  key_pair_q[2] <= pwdata;
				REG_KEY_67:  key_pair_q[3] <= pwdata;
				REG_DECRYPT: decrypt_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KEY_01:  prdata = key_pair_q[0];
			REG_KEY_23:  prdata = key_pair_q[1];
			REG_KEY_45:  prdata = key_pair_q[2];
			REG_KEY_67:  prdata = key_pair_q[3];
			REG_DECRYPT: prdata = {{(PDATA_W-1){1'b0}}, decrypt_q};
			default:     prdata = '0;
		endcase
	end

	// even word in the upper half of each pair
	always_comb begin
		for (int k = 0; k < KEY_WORDS; k++) begin
			keys[k] = key_pair_q[k/2][(1 - k%2)*32 +: 32];
		end
	end

	assign decrypt = decrypt_q;

endmodule

FILE: rtl/gbc_round.sv
module gbc_round import gbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  half_pair_t up_blk,
	input  word_t      rkey,
	output logic       dn_valid,
	input  logic       dn_ready,
	output half_pair_t dn_blk
);

	logic       valid_s1;
	half_pair_t blk_s1;
	word_t      f_val;

	assign up_ready = !valid_s1 || dn_ready;

	always_comb begin
		word_t sum;
		word_t sub;
		sum   = up_blk.right + rkey;
		sub   = substitute(sum);
		f_val = {sub[20:0], sub[31:21]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			blk_s1.left  <= up_blk.right;
			blk_s1.right <= f_val ^ up_blk.left;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_blk   = blk_s1;

endmodule

FILE: rtl/gost_block_cipher_ecb.sv
// channel  | dir | beat payload             | handshake
// blk_in   | in  | left_half, right_half    | valid/ready
// blk_out  | out | out_left, out_right      | valid/ready
// apb      | in  | 64-bit key pairs, mode   | psel/penable, pready tied high
//
// one beat per cycle in and out while blk_out is not stalled
// 32 registered round stages, one feistel round per stage
// reset clears the stage valid bits, the key registers and the mode
// a stall on blk_out fills empty stages first, then backs up to blk_in
module gost_block_cipher_ecb import gbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	gbc_in_if.sink             blk_in,
	gbc_out_if.source          blk_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	key_words_t keys;
	logic       decrypt;

	logic       stg_valid [ROUNDS+1];
	logic       stg_ready [ROUNDS+1];
	half_pair_t stg_blk   [ROUNDS+1];

	gbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.keys    (keys),
		.decrypt (decrypt)
	);

	assign stg_valid[0]       = blk_in.valid;
	assign stg_blk[0].left    = blk_in.left_half;
	assign stg_blk[0].right   = blk_in.right_half;
	assign blk_in.ready       = stg_ready[0];

	for (genvar i = 0; i < ROUNDS; i++) begin : g_round
		gbc_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stg_valid[i]),
			.up_ready (stg_ready[i]),
			.up_blk   (stg_blk[i]),
			.rkey     (keys[key_idx(rnd_idx_t'(i), decrypt)]),
			.dn_valid (stg_valid[i+1]),
			.dn_ready (stg_ready[i+1]),
			.dn_blk   (stg_blk[i+1])
		);
	end

	assign blk_out.valid     = stg_valid[ROUNDS];
	assign blk_out.out_left  = stg_blk[ROUNDS].left;
	assign blk_out.out_right = stg_blk[ROUNDS].right;
	assign stg_ready[ROUNDS] = blk_out.ready;

endmodule

FILE: rtl/gbc_checker.sv
module gbc_checker import gbc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input word_t              out_left,
	input word_t              out_right,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata,
	input logic               pready
);

	logic key_wr;
	assign key_wr = psel && penable && pwrite && (paddr[PADDR_W-1:3] < REG_DECRYPT);

	a_pready_high: assert property (@(posedge clk) pready)
		else $error("pready dropped");

	a_no_out_after_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result beat right after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
		else $error("stalled result beat changed");

	a_ready_flows: assert property (@(posedge clk) out_ready |-> in_ready)
		else $error("input blocked while output drains");

	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		key_wr ##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata))
		else $error("key register readback mismatch");

endmodule

bind gost_block_cipher_ecb gbc_checker u_gbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (blk_in.ready),
	.out_valid (blk_out.valid),
	.out_ready (blk_out.ready),
	.out_left  (blk_out.out_left),
	.out_right (blk_out.out_right),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready)
);

FILE: tb/sv/gost_block_cipher_ecb_tb.sv
`timescale 1ns / 1ps

module gost_block_cipher_ecb_tb;
	import gbc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 40;

	localparam int sbox_tab [8][16] = '{
		'{4, 10, 9, 2, 13, 8, 0, 14, 6, 11, 1, 12, 7, 15, 5, 3},
		'{14, 11, 4, 12, 6, 13, 15, 10, 2, 3, 8, 1, 0, 7, 5, 9},
		'{5, 8, 1, 13, 10, 3, 4, 2, 14, 15, 12, 7, 6, 0, 9, 11},
		'{7, 13, 10, 1, 0, 8, 9, 15, 14, 4, 6, 12, 11, 2, 5, 3},
		'{6, 12, 7, 1, 5, 15, 13, 8, 4, 10, 9, 14, 0, 3, 11, 2},
		'{4, 11, 10, 0, 7, 2, 1, 13, 3, 6, 8, 5, 9, 12, 15, 14},
		'{13, 11, 4, 1, 3, 15, 5, 9, 0, 10, 14, 7, 6, 8, 2, 12},
		'{1, 15, 13, 0, 5, 7, 10, 4, 9, 2, 3, 14, 6, 11, 8, 12}
	};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	gbc_in_if  blk_in ();
	gbc_out_if blk_out ();

	gost_block_cipher_ecb dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk_in  (blk_in),
		.blk_out (blk_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow copy of the key and mode registers
	logic [63:0] key_pairs [4];
	logic        decrypt_on;

	half_pair_t pending_blocks [$];
	int         err_count;
	int         cycle_count;
	int         send_gap_pct;
	int         stall_pct;
	int         stall_left;

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	// 32 feistel rounds with the current key and mode
	function automatic half_pair_t run_rounds(word_t l, word_t r);
		word_t      sum;
		word_t      subst;
		word_t      f;
		word_t      t;
		int         rnd;
		int         k;
		half_pair_t res;
		for (int i = 0; i < 32; i++) begin
			rnd = decrypt_on ? 31 - i : i;
			k = (rnd < 24) ? rnd % 8 : 7 - rnd % 8;
			sum = r + (k[0] ? key_pairs[k / 2][31:0] : key_pairs[k / 2][63:32]);
			for (int n = 0; n < 8; n++) begin
				subst[(7-n)*4 +: 4] = 4'(sbox_tab[n][sum[(7-n)*4 +: 4]]);
			end
			f = {subst[20:0], subst[31:21]};
			t = r;
			r = f ^ l;
			l = t;
		end
		res.left = l;
		res.right = r;
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(int pct);
		if (int'($urandom_range(99)) >= pct) begin
			return 0;
		end
		if ($urandom_range(7) == 0) begin
			return int'($urandom_range(48, 12));
		end
		return int'($urandom_range(3, 1));
	endfunction

	task automatic send_block(word_t l, word_t r);
		int gap;
		gap = pick_gap(send_gap_pct);
		if (gap > 0) begin
			blk_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		blk_in.valid <= 1'b1;
		blk_in.left_half <= l;
		blk_in.right_half <= r;
		do @(posedge clk); while (!blk_in.ready);
		pending_blocks.push_back(run_rounds(l, r));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		blk_in.valid <= 1'b0;
		while (pending_blocks.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic reg_write(int idx, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * 8);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == int'(REG_DECRYPT)) begin
			decrypt_on = value[0];
		end else if (idx < int'(REG_DECRYPT)) begin
			key_pairs[idx] = value;
		end
		@(negedge clk);
	endtask

	task automatic check_regs();
		logic [63:0] want;
		for (int idx = int'(REG_KEY_01); idx <= int'(REG_DECRYPT); idx++) begin
			want = (idx == int'(REG_DECRYPT)) ? {63'b0, decrypt_on} : key_pairs[idx];
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= PADDR_W'(idx * 8);
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata !== want) begin
				$display("%0t: register %0d readback mismatch, expected %h, got %h",
					$time, idx, want, prdata);
				err_count++;
			end
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic test_reset_state();
		check_regs();
		send_block(32'h0000_0000, 32'h0000_0000);
		send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(32'h0000_0000, 32'hFFFF_FFFF);
		send_block(32'hFFFF_FFFF, 32'h0000_0000);
		send_block(32'hAAAA_AAAA, 32'h5555_5555);
		send_block(32'h8000_0000, 32'h0000_0001);
		send_block(32'hFEDC_BA98, 32'h7654_3210);
		wait_idle();
	endtask

	task automatic test_key_extremes();
		for (int idx = int'(REG_KEY_01); idx <= int'(REG_KEY_67); idx++) begin
			reg_write(idx, '1);
		end
		check_regs();
		send_block(32'h0000_0000, 32'h0000_0000);
		send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_idle();
		reg_write(int'(REG_KEY_01), 64'h0123_4567_89AB_CDEF);
		reg_write(int'(REG_KEY_23), 64'hFEDC_BA98_7654_3210);
		reg_write(int'(REG_KEY_45), 64'h0000_0000_FFFF_FFFF);
		reg_write(int'(REG_KEY_67), 64'h8000_0001_7FFF_FFFE);
		send_block(32'h1234_5678, 32'h9ABC_DEF0);
		wait_idle();
	endtask

	// only bit 0 of the mode write counts, then encrypt and undo it
	task automatic test_mode_select();
		half_pair_t ct;
		reg_write(int'(REG_DECRYPT), '1);
		check_regs();
		send_block(32'h0000_0000, 32'h0000_0000);
		send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(32'hDEAD_BEEF, 32'h0BAD_F00D);
		wait_idle();
		reg_write(int'(REG_DECRYPT), 64'hFFFF_FFFF_FFFF_FFFE);
		check_regs();
		send_block(32'h0000_0000, 32'hFFFF_FFFF);
		ct = run_rounds(32'hC0FF_EE00, 32'h1357_9BDF);
		send_block(32'hC0FF_EE00, 32'h1357_9BDF);
		wait_idle();
		reg_write(int'(REG_DECRYPT), 64'h1);
		send_block(ct.right, ct.left);
		wait_idle();
	endtask

	task automatic test_unmapped_writes();
		for (int idx = int'(REG_DECRYPT) + 1; idx < 8; idx++) begin
			reg_write(idx, '1);
		end
		check_regs();
		send_block(32'h5A5A_5A5A, 32'hA5A5_A5A5);
		send_block(32'h0F0F_0F0F, 32'hF0F0_F0F0);
		wait_idle();
	endtask

	task automatic test_random_phases();
		word_t l;
		word_t r;
		for (int phase = 0; phase < 5; phase++) begin
			for (int idx = int'(REG_KEY_01); idx <= int'(REG_KEY_67); idx++) begin
				case ($urandom_range(5))
					0: reg_write(idx, '0);
					1: reg_write(idx, '1);
					default: reg_write(idx, {$urandom, $urandom});
				endcase
			end
			// random upper bits on the mode write
			reg_write(int'(REG_DECRYPT), {$urandom, $urandom});
			if ($urandom_range(1) == 0) begin
				reg_write(int'($urandom_range(7, int'(REG_DECRYPT) + 1)), {$urandom, $urandom});
			end
			send_gap_pct = (phase == 0) ? 0 : int'($urandom_range(60));
			stall_pct = (phase == 0) ? 0 : int'($urandom_range(60));
			for (int n = 0; n < 96; n++) begin
				l = $urandom;
				r = $urandom;
				case ($urandom_range(15))
					0: l = '0;
					1: l = '1;
					2: r = '0;
					3: r = '1;
					default: ;
				endcase
				send_block(l, r);
			end
			wait_idle();
		end
	endtask

	// long output stalls back the pipe up into the input
	task automatic test_backpressure();
		send_gap_pct = 0;
		stall_pct = 80;
		for (int n = 0; n < 40; n++) begin
			send_block($urandom, $urandom);
		end
		// hold off until every block has come out
		wait_idle();
		stall_pct = 0;
		for (int n = 0; n < 20; n++) begin
			send_block($urandom, $urandom);
		end
		wait_idle();
		stall_pct = 30;
		send_gap_pct = 30;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			blk_out.ready <= 1'b0;
		end else begin
			stall_left <= pick_gap(stall_pct);
			blk_out.ready <= (stall_pct == 0) || ($urandom_range(99) >= 25);
		end
	end

	always @(posedge clk) begin : result_check
		half_pair_t want;
		if (blk_out.valid === 1'b1 && blk_out.ready === 1'b1) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: result beat with no block pending, got %h %h",
					$time, blk_out.out_left, blk_out.out_right);
				err_count++;
			end else begin
				want = pending_blocks.pop_front();
				if (blk_out.out_left !== want.left) begin
					$display("%0t: out_left mismatch, expected %h, got %h",
						$time, want.left, blk_out.out_left);
					err_count++;
				end
				if (blk_out.out_right !== want.right) begin
					$display("%0t: out_right mismatch, expected %h, got %h",
						$time, want.right, blk_out.out_right);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d blocks pending", $time, pending_blocks.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		blk_in.valid = 1'b0;
		blk_in.left_half = '0;
		blk_in.right_half = '0;
		blk_out.ready = 1'b0;
		err_count = 0;
		cycle_count = 0;
		stall_left = 0;
		send_gap_pct = 30;
		stall_pct = 30;
		decrypt_on = 1'b0;
		for (int idx = 0; idx < 4; idx++) begin
			key_pairs[idx] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_key_extremes();
		test_mode_select();
		test_unmapped_writes();
		test_random_phases();
		test_backpressure();

		// catch any stray beats after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
